>>> hw/rtl/psdn_pkg.sv
`timescale 1ns / 1ps
// Package for the path separator, dot and space normalizer.
// Holds the word types, the command passed from front to back, and shared constants.
// Depends on nothing; every other file refers to it by scoped names.
package psdn_pkg;

  localparam int SYM_W = 16;
  localparam int CNT_W = 9;
  localparam int ST_W = 2;
  localparam int UNC_W = 3;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam int MAX_PATH_LEN = 260;
  localparam int SEEN_W = $clog2(MAX_PATH_LEN + 1);

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW = $clog2(FIFO_DEPTH);

  localparam logic [CNT_W-1:0] RUN_MAX = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] HELD_DOT_MAX = CNT_W'(2);
  localparam logic [CNT_W-1:0] ONE_COPY = CNT_W'(1);

  localparam logic [SYM_W-1:0] CH_DOT = 16'h002E;
  localparam logic [SYM_W-1:0] CH_SPACE = 16'h0020;
  localparam logic [SYM_W-1:0] CH_SLASH = 16'h002F;
  localparam logic [SYM_W-1:0] CH_BSLASH = 16'h005C;
  localparam logic [SYM_W-1:0] PRIMARY_RESET = 16'd92;
  localparam logic [SYM_W-1:0] ALTERNATE_RESET = 16'd47;

  localparam logic REG_PRIMARY = 1'b0;
  localparam logic REG_ALTERNATE = 1'b1;

  localparam logic [ST_W-1:0] ST_OK = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_BAD_UNC = 2'd2;
  localparam logic [ST_W-1:0] ST_TOO_LONG = 2'd3;

  localparam logic [UNC_W-1:0] UNC_NONE = 3'd0;
  localparam logic [UNC_W-1:0] UNC_ONE = 3'd1;
  localparam logic [UNC_W-1:0] UNC_TWO = 3'd2;
  localparam logic [UNC_W-1:0] UNC_THIRD = 3'd3;
  localparam logic [UNC_W-1:0] UNC_DONE = 3'd4;

  typedef struct packed {
    logic [SYM_W-1:0] path_char;
    logic final_char;
  } in_item_t;

  typedef struct packed {
    logic [SYM_W-1:0] out_symbol;
    logic [CNT_W-1:0] repeat_count;
    logic end_of_path;
    logic [ST_W-1:0] path_status;
  } out_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] dot_cnt;
    logic [CNT_W-1:0] spc_cnt;
    logic sym_vld;
    logic [SYM_W-1:0] sym;
    logic [CNT_W-1:0] fdot_cnt;
    logic fin;
    logic too_long;
  } cmd_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v != RUN_MAX) ? v + CNT_W'(1) : v;
  endfunction

  function automatic logic [UNC_W-1:0] unc_step(input logic [UNC_W-1:0] ph, input logic bs);
    case (ph)
      UNC_NONE: unc_step = bs ? UNC_ONE : UNC_DONE;
      UNC_ONE: unc_step = bs ? UNC_TWO : UNC_DONE;
      UNC_TWO: unc_step = bs ? UNC_THIRD : UNC_TWO;
      default: unc_step = UNC_DONE;
    endcase
  endfunction

  // The check only sees the first four copies of a run.
  function automatic logic [UNC_W-1:0] unc_run(input logic [UNC_W-1:0] ph, input logic bs,
                                               input logic [CNT_W-1:0] cnt);
    logic [UNC_W-1:0] p;
    p = ph;
    for (int i = 0; i < 4; i++) begin
      if (cnt > CNT_W'(i)) begin
        p = unc_step(p, bs);
      end
    end
    unc_run = p;
  endfunction

endpackage

>>> hw/rtl/path_separator_dot_space_normalizer.sv
`timescale 1ns / 1ps
// Top level of the path normalizer: configuration registers, front end, queue, back end.
// Depends on psdn_pkg, psdn_front, psdn_cmd_fifo and psdn_back.
//
//   Channel   Ports                                   Moves
//   input     in_valid, in_ready, in_data             one path character word
//   result    out_valid, out_ready, out_data          one run or status word
//   config    cfg_psel .. cfg_pready (APB style)      separator registers at 0x0, 0x4
//
// The front end takes one character word per cycle while the four-entry queue has room.
// The back end sends one result word per cycle through its output register while out_ready
// stays high; an input item makes none to four words, and a command is first loaded into
// the back end's current register when the back end was idle.
// Synchronous reset clears all path state and sets the separators to 92 and 47.
// A stalled result side fills the queue, after which in_ready drops.
module path_separator_dot_space_normalizer (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  psdn_pkg::in_item_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output psdn_pkg::out_item_t out_data,
  input  logic cfg_psel,
  input  logic cfg_penable,
  input  logic cfg_pwrite,
  input  logic [psdn_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [psdn_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [psdn_pkg::CFG_DW-1:0] cfg_prdata,
  output logic cfg_pready
);

  logic [psdn_pkg::SYM_W-1:0] primary_r, alternate_r;
  logic cfg_wr;
  logic q_full, q_push, q_pop, q_vld;
  psdn_pkg::cmd_t q_cmd, q_head;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == psdn_pkg::REG_ALTERNATE) ?
                      psdn_pkg::CFG_DW'(alternate_r) : psdn_pkg::CFG_DW'(primary_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primary_r <= psdn_pkg::PRIMARY_RESET;
      alternate_r <= psdn_pkg::ALTERNATE_RESET;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == psdn_pkg::REG_PRIMARY) begin
        primary_r <= cfg_pwdata[psdn_pkg::SYM_W-1:0];
      end else begin
        alternate_r <= cfg_pwdata[psdn_pkg::SYM_W-1:0];
      end
    end
  end

  psdn_front u_front (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .primary_sep(primary_r),
    .alternate_sep(alternate_r),
    .q_full(q_full),
    .q_push(q_push),
    .q_cmd(q_cmd)
  );

  psdn_cmd_fifo u_fifo (
    .clk(clk),
    .rst_n(rst_n),
    .push(q_push),
    .push_data(q_cmd),
    .full(q_full),
    .pop(q_pop),
    .head_vld(q_vld),
    .head_data(q_head)
  );

  psdn_back u_back (
    .clk(clk),
    .rst_n(rst_n),
    .q_vld(q_vld),
    .q_data(q_head),
    .q_pop(q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

endmodule

>>> hw/rtl/psdn_front.sv
`timescale 1ns / 1ps
// Front end: accepts character words, tracks held dots and spaces, builds run commands.
// Depends on psdn_pkg.
module psdn_front (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  psdn_pkg::in_item_t in_data,
  input  logic [psdn_pkg::SYM_W-1:0] primary_sep,
  input  logic [psdn_pkg::SYM_W-1:0] alternate_sep,
  input  logic q_full,
  output logic q_push,
  output psdn_pkg::cmd_t q_cmd
);

  logic [psdn_pkg::CNT_W-1:0] dots_r, dots_nxt;
  logic [psdn_pkg::CNT_W-1:0] spc_r, spc_nxt;
  logic sepw_r, sepw_nxt;
  logic segs_r, segs_nxt;
  logic [psdn_pkg::SEEN_W-1:0] seen_r, seen_nxt, seen_inc;
  logic [psdn_pkg::SYM_W-1:0] c;
  logic [psdn_pkg::CNT_W-1:0] held;
  logic first;
  logic accept;
  psdn_pkg::cmd_t cmd;

  assign in_ready = !q_full;
  assign accept = in_valid && in_ready;
  assign q_cmd = cmd;

  always_comb begin
    cmd = '0;
    dots_nxt = dots_r;
    spc_nxt = spc_r;
    sepw_nxt = sepw_r;
    segs_nxt = segs_r;
    c = in_data.path_char;
    first = (seen_r == '0);
    seen_inc = (seen_r < psdn_pkg::SEEN_W'(psdn_pkg::MAX_PATH_LEN)) ?
               seen_r + psdn_pkg::SEEN_W'(1) : seen_r;
    seen_nxt = seen_inc;
    held = (segs_r && dots_r > psdn_pkg::HELD_DOT_MAX) ? psdn_pkg::HELD_DOT_MAX : dots_r;
    if (first && (c == psdn_pkg::CH_SLASH || c == psdn_pkg::CH_BSLASH)) begin
      cmd.sym_vld = 1'b1;
      cmd.sym = psdn_pkg::CH_BSLASH;
    end else if (c == primary_sep || c == alternate_sep) begin
      cmd.dot_cnt = held;
      dots_nxt = '0;
      spc_nxt = '0;
      segs_nxt = 1'b1;
      if (!sepw_r) begin
        sepw_nxt = 1'b1;
        cmd.sym_vld = 1'b1;
        cmd.sym = primary_sep;
      end
    end else if (c == psdn_pkg::CH_DOT && segs_r) begin
      dots_nxt = psdn_pkg::sat_inc(dots_r);
      sepw_nxt = 1'b0;
      spc_nxt = '0;
    end else begin
      sepw_nxt = 1'b0;
      if (c == psdn_pkg::CH_SPACE) begin
        spc_nxt = psdn_pkg::sat_inc(spc_r);
      end else begin
        cmd.dot_cnt = dots_r;
        dots_nxt = '0;
        segs_nxt = 1'b0;
        cmd.spc_cnt = spc_r;
        spc_nxt = '0;
        cmd.sym_vld = 1'b1;
        cmd.sym = c;
      end
    end
    if (in_data.final_char) begin
      cmd.fin = 1'b1;
      cmd.too_long = (seen_inc == psdn_pkg::SEEN_W'(psdn_pkg::MAX_PATH_LEN));
      cmd.fdot_cnt = (segs_nxt && dots_nxt > psdn_pkg::HELD_DOT_MAX) ?
                     psdn_pkg::HELD_DOT_MAX : dots_nxt;
      dots_nxt = '0;
      spc_nxt = '0;
      sepw_nxt = 1'b0;
      segs_nxt = 1'b1;
      seen_nxt = '0;
    end
    q_push = accept && (cmd.dot_cnt != '0 || cmd.spc_cnt != '0 || cmd.sym_vld ||
                        cmd.fdot_cnt != '0 || cmd.fin);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dots_r <= '0;
      spc_r <= '0;
      sepw_r <= 1'b0;
      segs_r <= 1'b1;
      seen_r <= '0;
    end else if (accept) begin
      dots_r <= dots_nxt;
      spc_r <= spc_nxt;
      sepw_r <= sepw_nxt;
      segs_r <= segs_nxt;
      seen_r <= seen_nxt;
    end
  end

endmodule

>>> hw/rtl/psdn_cmd_fifo.sv
`timescale 1ns / 1ps
// Short command queue between the front end and the back end.
// Depends on psdn_pkg.
module psdn_cmd_fifo (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  psdn_pkg::cmd_t push_data,
  output logic full,
  input  logic pop,
  output logic head_vld,
  output psdn_pkg::cmd_t head_data
);

  psdn_pkg::cmd_t mem_r [psdn_pkg::FIFO_DEPTH];
  logic [psdn_pkg::FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [psdn_pkg::FIFO_AW:0] count_r, count_nxt;
  logic do_push, do_pop;

  assign full = (count_r == (psdn_pkg::FIFO_AW + 1)'(psdn_pkg::FIFO_DEPTH));
  assign head_vld = (count_r != '0);
  assign head_data = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop = pop && head_vld;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + (psdn_pkg::FIFO_AW + 1)'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - (psdn_pkg::FIFO_AW + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + psdn_pkg::FIFO_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + psdn_pkg::FIFO_AW'(1);
      end
      count_r <= count_nxt;
    end
  end

endmodule

>>> hw/rtl/psdn_back.sv
`timescale 1ns / 1ps
// Back end: expands each command into run words and, for a final command, the closing status word.
// Tracks written length and the UNC form check. Depends on psdn_pkg.
module psdn_back (
  input  logic clk,
  input  logic rst_n,
  input  logic q_vld,
  input  psdn_pkg::cmd_t q_data,
  output logic q_pop,
  output logic out_valid,
  input  logic out_ready,
  output psdn_pkg::out_item_t out_data
);

  psdn_pkg::cmd_t cur_r, cur_nxt, left;
  logic cur_vld_r, cur_vld_nxt;
  psdn_pkg::out_item_t out_r, out_nxt, emit;
  logic out_vld_r, out_vld_nxt;
  logic [psdn_pkg::CNT_W-1:0] written_r, written_nxt;
  logic [psdn_pkg::UNC_W-1:0] unc_r, unc_nxt;
  logic [psdn_pkg::CNT_W:0] sum;
  logic [psdn_pkg::SYM_W-1:0] run_sym;
  logic [psdn_pkg::CNT_W-1:0] run_cnt;
  logic [psdn_pkg::ST_W-1:0] status;
  logic is_run, left_empty, out_free;

  assign out_valid = out_vld_r;
  assign out_data = out_r;

  always_comb begin
    cur_nxt = cur_r;
    cur_vld_nxt = cur_vld_r;
    out_nxt = out_r;
    out_vld_nxt = out_vld_r;
    written_nxt = written_r;
    unc_nxt = unc_r;
    q_pop = 1'b0;
    out_free = !out_vld_r || out_ready;
    left = cur_r;
    run_sym = '0;
    run_cnt = '0;
    is_run = 1'b1;
    if (cur_r.dot_cnt != '0) begin
      run_sym = psdn_pkg::CH_DOT;
      run_cnt = cur_r.dot_cnt;
      left.dot_cnt = '0;
    end else if (cur_r.spc_cnt != '0) begin
      run_sym = psdn_pkg::CH_SPACE;
      run_cnt = cur_r.spc_cnt;
      left.spc_cnt = '0;
    end else if (cur_r.sym_vld) begin
      run_sym = cur_r.sym;
      run_cnt = psdn_pkg::ONE_COPY;
      left.sym_vld = 1'b0;
    end else if (cur_r.fdot_cnt != '0) begin
      run_sym = psdn_pkg::CH_DOT;
      run_cnt = cur_r.fdot_cnt;
      left.fdot_cnt = '0;
    end else begin
      is_run = 1'b0;
      left.fin = 1'b0;
    end
    left_empty = (left.dot_cnt == '0) && (left.spc_cnt == '0) && !left.sym_vld &&
                 (left.fdot_cnt == '0) && !left.fin;
    if (cur_r.too_long) begin
      status = psdn_pkg::ST_TOO_LONG;
    end else if (written_r == '0) begin
      status = psdn_pkg::ST_EMPTY;
    end else if (unc_r == psdn_pkg::UNC_TWO || unc_r == psdn_pkg::UNC_THIRD) begin
      status = psdn_pkg::ST_BAD_UNC;
    end else begin
      status = psdn_pkg::ST_OK;
    end
    emit.out_symbol = run_sym;
    emit.repeat_count = run_cnt;
    emit.end_of_path = !is_run;
    emit.path_status = is_run ? psdn_pkg::ST_OK : status;
    sum = {1'b0, written_r} + {1'b0, run_cnt};

    if (out_free) begin
      out_vld_nxt = 1'b0;
    end
    if (!cur_vld_r) begin
      cur_nxt = q_data;
      cur_vld_nxt = q_vld;
      q_pop = q_vld;
    end else if (out_free) begin
      out_nxt = emit;
      out_vld_nxt = 1'b1;
      if (is_run) begin
        written_nxt = sum[psdn_pkg::CNT_W] ? psdn_pkg::RUN_MAX : sum[psdn_pkg::CNT_W-1:0];
        unc_nxt = psdn_pkg::unc_run(unc_r, run_sym == psdn_pkg::CH_BSLASH, run_cnt);
      end else begin
        written_nxt = '0;
        unc_nxt = psdn_pkg::UNC_NONE;
      end
      if (left_empty) begin
        cur_nxt = q_data;
        cur_vld_nxt = q_vld;
        q_pop = q_vld;
      end else begin
        cur_nxt = left;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
      written_r <= '0;
      unc_r <= psdn_pkg::UNC_NONE;
    end else begin
      cur_vld_r <= cur_vld_nxt;
      out_vld_r <= out_vld_nxt;
      written_r <= written_nxt;
      unc_r <= unc_nxt;
    end
  end

endmodule

>>> dv/path_separator_dot_space_normalizer_test.sv
`timescale 1ns / 1ps
// Testbench for path_separator_dot_space_normalizer: drives character words and separator
// writes, predicts the run and status words in a small scoreboard and compares them.
// Depends on psdn_pkg and the normalizer RTL only.
module path_separator_dot_space_normalizer_test;

  localparam logic [psdn_pkg::CFG_AW-1:0] ADDR_PRIMARY = {psdn_pkg::REG_PRIMARY, 2'b00};
  localparam logic [psdn_pkg::CFG_AW-1:0] ADDR_ALTERNATE = {psdn_pkg::REG_ALTERNATE, 2'b00};
  localparam int LONG_STALL = 300;

  class run_scoreboard;
    logic [psdn_pkg::SYM_W-1:0] primary;
    logic [psdn_pkg::SYM_W-1:0] alternate;
    logic [psdn_pkg::CNT_W-1:0] dots;
    logic [psdn_pkg::CNT_W-1:0] spaces;
    logic [psdn_pkg::CNT_W-1:0] written;
    logic [psdn_pkg::UNC_W-1:0] unc;
    bit sep_written;
    bit seg_start;
    int seen;
    int mismatch_count;
    psdn_pkg::out_item_t expected_runs[$];

    function new();
      primary = psdn_pkg::PRIMARY_RESET;
      alternate = psdn_pkg::ALTERNATE_RESET;
      mismatch_count = 0;
      clear_path();
    endfunction

    function void clear_path();
      dots = '0;
      spaces = '0;
      written = '0;
      unc = psdn_pkg::UNC_NONE;
      sep_written = 1'b0;
      seg_start = 1'b1;
      seen = 0;
    endfunction

    function logic [psdn_pkg::UNC_W-1:0] unc_next(logic [psdn_pkg::UNC_W-1:0] ph, bit bs);
      case (ph)
        psdn_pkg::UNC_NONE: return bs ? psdn_pkg::UNC_ONE : psdn_pkg::UNC_DONE;
        psdn_pkg::UNC_ONE: return bs ? psdn_pkg::UNC_TWO : psdn_pkg::UNC_DONE;
        psdn_pkg::UNC_TWO: return bs ? psdn_pkg::UNC_THIRD : psdn_pkg::UNC_TWO;
        default: return psdn_pkg::UNC_DONE;
      endcase
    endfunction

    function logic [psdn_pkg::CNT_W-1:0] held_dots();
      return (seg_start && dots > psdn_pkg::HELD_DOT_MAX) ? psdn_pkg::HELD_DOT_MAX : dots;
    endfunction

    function logic [psdn_pkg::CNT_W-1:0] sat_add_one(logic [psdn_pkg::CNT_W-1:0] v);
      return (v == psdn_pkg::RUN_MAX) ? v : v + psdn_pkg::CNT_W'(1);
    endfunction

    function void push_run(logic [psdn_pkg::SYM_W-1:0] sym, logic [psdn_pkg::CNT_W-1:0] cnt);
      psdn_pkg::out_item_t w;
      int total;
      if (cnt == 0) return;
      total = int'(written) + int'(cnt);
      written = (total > int'(psdn_pkg::RUN_MAX)) ? psdn_pkg::RUN_MAX :
                psdn_pkg::CNT_W'(total);
      for (int i = 0; i < 4; i++) begin
        if (i < int'(cnt)) unc = unc_next(unc, sym == psdn_pkg::CH_BSLASH);
      end
      w.out_symbol = sym;
      w.repeat_count = cnt;
      w.end_of_path = 1'b0;
      w.path_status = psdn_pkg::ST_OK;
      expected_runs.push_back(w);
    endfunction

    function void note_char(psdn_pkg::in_item_t w);
      logic [psdn_pkg::SYM_W-1:0] c;
      psdn_pkg::out_item_t st;
      bit first;
      c = w.path_char;
      first = (seen == 0);
      if (seen < psdn_pkg::MAX_PATH_LEN) seen++;
      if (first && (c == psdn_pkg::CH_SLASH || c == psdn_pkg::CH_BSLASH)) begin
        push_run(psdn_pkg::CH_BSLASH, psdn_pkg::ONE_COPY);
      end else if (c == primary || c == alternate) begin
        push_run(psdn_pkg::CH_DOT, held_dots());
        dots = '0;
        spaces = '0;
        seg_start = 1'b1;
        if (!sep_written) begin
          sep_written = 1'b1;
          push_run(primary, psdn_pkg::ONE_COPY);
        end
      end else if (c == psdn_pkg::CH_DOT && seg_start) begin
        dots = sat_add_one(dots);
        sep_written = 1'b0;
        spaces = '0;
      end else begin
        sep_written = 1'b0;
        if (c == psdn_pkg::CH_SPACE) begin
          spaces = sat_add_one(spaces);
        end else begin
          push_run(psdn_pkg::CH_DOT, dots);
          dots = '0;
          seg_start = 1'b0;
          push_run(psdn_pkg::CH_SPACE, spaces);
          spaces = '0;
          push_run(c, psdn_pkg::ONE_COPY);
        end
      end
      if (w.final_char) begin
        push_run(psdn_pkg::CH_DOT, held_dots());
        st.out_symbol = '0;
        st.repeat_count = '0;
        st.end_of_path = 1'b1;
        if (seen >= psdn_pkg::MAX_PATH_LEN) st.path_status = psdn_pkg::ST_TOO_LONG;
        else if (written == 0) st.path_status = psdn_pkg::ST_EMPTY;
        else if (unc == psdn_pkg::UNC_TWO || unc == psdn_pkg::UNC_THIRD)
          st.path_status = psdn_pkg::ST_BAD_UNC;
        else st.path_status = psdn_pkg::ST_OK;
        expected_runs.push_back(st);
        clear_path();
      end
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
      mismatch_count++;
    endtask

    task check_run(psdn_pkg::out_item_t w);
      psdn_pkg::out_item_t e;
      if (expected_runs.size() == 0) begin
        report_mismatch("unexpected word", 32'(w), 32'h0);
        return;
      end
      e = expected_runs.pop_front();
      if (w.out_symbol !== e.out_symbol)
        report_mismatch("out_symbol", 32'(w.out_symbol), 32'(e.out_symbol));
      if (w.repeat_count !== e.repeat_count)
        report_mismatch("repeat_count", 32'(w.repeat_count), 32'(e.repeat_count));
      if (w.end_of_path !== e.end_of_path)
        report_mismatch("end_of_path", 32'(w.end_of_path), 32'(e.end_of_path));
      if (w.path_status !== e.path_status)
        report_mismatch("path_status", 32'(w.path_status), 32'(e.path_status));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  psdn_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  psdn_pkg::out_item_t out_data;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [psdn_pkg::CFG_AW-1:0] cfg_paddr = '0;
  logic [psdn_pkg::CFG_DW-1:0] cfg_pwdata = '0;
  logic [psdn_pkg::CFG_DW-1:0] cfg_prdata;
  logic cfg_pready;

  logic stall_go = 1'b0;
  int hold_left = 0;
  int sender_idle = 0;
  int receiver_idle = 0;
  logic [psdn_pkg::SYM_W-1:0] path_buf[$];
  run_scoreboard sb = new();

  path_separator_dot_space_normalizer u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  function automatic bit roll_idle(int pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left = 0;
    end else if (stall_go) begin
      hold_left = LONG_STALL;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !roll_idle(receiver_idle);
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_char(in_data);
    if (rst_n && out_valid && out_ready) sb.check_run(out_data);
  end

  task automatic write_reg(input logic [psdn_pkg::CFG_AW-1:0] addr,
                           input logic [psdn_pkg::SYM_W-1:0] val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= psdn_pkg::CFG_DW'(val);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (addr == ADDR_PRIMARY) sb.primary = val;
    else sb.alternate = val;
    @(posedge clk);
  endtask

  task automatic set_separators(input logic [psdn_pkg::SYM_W-1:0] prim,
                                input logic [psdn_pkg::SYM_W-1:0] alt);
    write_reg(ADDR_PRIMARY, prim);
    write_reg(ADDR_ALTERNATE, alt);
  endtask

  task automatic send_char(input logic [psdn_pkg::SYM_W-1:0] c, input logic fin);
    psdn_pkg::in_item_t w;
    w.path_char = c;
    w.final_char = fin;
    while (roll_idle(sender_idle)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_data <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_buf();
    for (int i = 0; i < path_buf.size(); i++) begin
      send_char(path_buf[i], i == path_buf.size() - 1);
    end
  endtask

  function automatic logic [psdn_pkg::SYM_W-1:0] random_char();
    case ($urandom_range(9, 0))
      0, 1: return sb.primary;
      2: return sb.alternate;
      3: return psdn_pkg::CH_SLASH;
      4: return psdn_pkg::CH_BSLASH;
      5, 6: return psdn_pkg::CH_DOT;
      7: return psdn_pkg::CH_SPACE;
      8: return 16'h0061 + psdn_pkg::SYM_W'($urandom_range(25, 0));
      default: return psdn_pkg::SYM_W'($urandom());
    endcase
  endfunction

  task automatic random_paths(input int n_chars);
    int sent;
    int len;
    sent = 0;
    while (sent < n_chars) begin
      len = $urandom_range(12, 1);
      path_buf = {};
      for (int i = 0; i < len; i++) path_buf.push_back(random_char());
      send_buf();
      sent += len;
    end
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_runs.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    sender_idle = 38;
    receiver_idle = 59;
    set_separators(psdn_pkg::PRIMARY_RESET, psdn_pkg::ALTERNATE_RESET);
    path_buf = '{psdn_pkg::CH_SLASH};
    send_buf();
    path_buf = '{psdn_pkg::CH_BSLASH, psdn_pkg::CH_BSLASH};
    send_buf();
    path_buf = '{psdn_pkg::CH_BSLASH, psdn_pkg::CH_BSLASH, 16'hFFFF, psdn_pkg::CH_BSLASH};
    send_buf();
    path_buf = '{psdn_pkg::CH_SPACE};
    send_buf();
    path_buf = '{psdn_pkg::CH_DOT, psdn_pkg::CH_DOT, psdn_pkg::CH_DOT, psdn_pkg::CH_SLASH,
                 16'h0061, psdn_pkg::CH_SPACE, psdn_pkg::CH_SLASH, psdn_pkg::CH_DOT,
                 psdn_pkg::CH_DOT, psdn_pkg::CH_DOT, 16'h0000, psdn_pkg::CH_SPACE};
    send_buf();
    path_buf = '{16'h0078, psdn_pkg::CH_DOT, psdn_pkg::CH_SPACE, 16'h0079,
                 psdn_pkg::CH_SLASH, psdn_pkg::CH_DOT, psdn_pkg::CH_DOT, psdn_pkg::CH_DOT};
    send_buf();
    random_paths(35);
    wait_drain();

    set_separators(16'hFFFF, 16'h0000);
    stall_go <= 1'b1;
    @(posedge clk);
    stall_go <= 1'b0;
    random_paths(35);
    wait_drain();

    sender_idle = 59;
    receiver_idle = 38;
    set_separators(psdn_pkg::CH_DOT, psdn_pkg::CH_SPACE);
    random_paths(35);
    wait_drain();
    set_separators(psdn_pkg::CH_SLASH, psdn_pkg::CH_SLASH);
    random_paths(35);
    wait_drain();

    sender_idle = 0;
    receiver_idle = 0;
    set_separators(psdn_pkg::PRIMARY_RESET, psdn_pkg::ALTERNATE_RESET);
    random_paths(35);
    wait_drain();

    repeat (20) @(posedge clk);
    if (sb.mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/psdn_pkg.sv
hw/rtl/psdn_front.sv
hw/rtl/psdn_cmd_fifo.sv
hw/rtl/psdn_back.sv
hw/rtl/path_separator_dot_space_normalizer.sv
dv/path_separator_dot_space_normalizer_test.sv
